// ===== hdl/rts_pkg.sv =====
package rts_pkg;

    localparam int unsigned MsWidth = 49;

    // parser phases, one-hot
    typedef enum logic [6:0] {
        PH_LEAD       = 7'b0000001,
        PH_FIXED      = 7'b0000010,
        PH_SEP        = 7'b0000100,
        PH_FRAC_FIRST = 7'b0001000,
        PH_FRAC       = 7'b0010000,
        PH_OFFSET     = 7'b0100000,
        PH_DONE       = 7'b1000000
    } t_phase;

    // conversion sequencer states, one-hot
    typedef enum logic [4:0] {
        CV_IDLE = 5'b00001,
        CV_DAYS = 5'b00010,
        CV_SECS = 5'b00100,
        CV_MS   = 5'b01000,
        CV_OUT  = 5'b10000
    } t_cv_state;

    // captured fields of one timestamp
    typedef struct packed {
        logic        good;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
        logic [9:0]  millis;
        logic        zone_neg;
        logic [4:0]  zone_hour;
        logic [5:0]  zone_minute;
    } t_fields;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic do_days;
        logic do_secs;
        logic do_ms;
    } t_cmd;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || (c == 8'h09) || (c == 8'h0d) || (c == 8'h0a);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

// ===== hdl/rts_stream_if.sv =====
interface rts_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       last_char;
    modport source (output valid, char_byte, last_char, input ready);
    modport sink (input valid, char_byte, last_char, output ready);
endinterface

interface rts_result_if;
    logic                             valid;
    logic                             ready;
    logic                             ok;
    logic signed [rts_pkg::MsWidth-1:0] epoch_ms;
    modport source (output valid, ok, epoch_ms, input ready);
    modport sink (input valid, ok, epoch_ms, output ready);
endinterface

// ===== hdl/rts_parser.sv =====
// Character scanner: one character per cycle while i_take is high; the datapath captures its fields on last_char.
module rts_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [7:0]           i_char,
    input  logic                 i_last,
    output rts_pkg::t_fields     o_fields
);
    rts_pkg::t_phase r_phase, n_phase;
    logic [4:0]  r_pos, n_pos;
    logic [13:0] r_year, n_year;
    logic [6:0]  r_ylo, n_ylo;
    logic [6:0]  r_mon, n_mon, r_day, n_day, r_hr, n_hr, r_mi, n_mi, r_se, n_se;
    logic [9:0]  r_ms, n_ms;
    logic [1:0]  r_fd, n_fd;
    logic        r_neg, n_neg, r_bad, n_bad;
    logic [6:0]  r_zh, n_zh, r_zm, n_zm;
    logic [3:0]  dig;
    logic [4:0]  mdays;
    logic        leap, good;
    logic [9:0]  frac;

    assign dig = i_char[3:0];

    function automatic logic [6:0] acc7(input logic [6:0] a, input logic [3:0] d);
        return 7'(a * 7'd10 + 7'(d));
    endfunction

    // next-state scan of one character
    always_comb begin
        n_phase = r_phase; n_pos = r_pos; n_year = r_year; n_ylo = r_ylo; n_mon = r_mon;
        n_day = r_day; n_hr = r_hr; n_mi = r_mi; n_se = r_se; n_ms = r_ms; n_fd = r_fd;
        n_neg = r_neg; n_bad = r_bad; n_zh = r_zh; n_zm = r_zm;
        if (!r_bad) begin
            unique case (r_phase)
                rts_pkg::PH_LEAD, rts_pkg::PH_FIXED: begin
                    if (r_phase == rts_pkg::PH_FIXED || !rts_pkg::is_ws(i_char)) begin
                        n_phase = rts_pkg::PH_FIXED;
                        if (r_pos == 5'd4 || r_pos == 5'd7) begin
                            if (i_char != "-") n_bad = 1'b1;
                        end else if (r_pos == 5'd10) begin
                            if (i_char != "T" && i_char != "t") n_bad = 1'b1;
                        end else if (r_pos == 5'd13 || r_pos == 5'd16) begin
                            if (i_char != ":") n_bad = 1'b1;
                        end else if (!rts_pkg::is_digit(i_char)) begin
                            n_bad = 1'b1;
                        end else if (r_pos < 5'd4) begin
                            n_year = 14'(r_year * 14'd10 + 14'(dig));
                            // last two year digits, for the century test
                            if (r_pos >= 5'd2) n_ylo = acc7(r_ylo, dig);
                        end else if (r_pos < 5'd7) begin
                            n_mon = acc7(r_mon, dig);
                        end else if (r_pos < 5'd10) begin
                            n_day = acc7(r_day, dig);
                        end else if (r_pos < 5'd13) begin
                            n_hr = acc7(r_hr, dig);
                        end else if (r_pos < 5'd16) begin
                            n_mi = acc7(r_mi, dig);
                        end else begin
                            n_se = acc7(r_se, dig);
                        end
                        n_pos = r_pos + 5'd1;
                        if (r_pos == 5'd18) n_phase = rts_pkg::PH_SEP;
                    end
                end
                rts_pkg::PH_SEP, rts_pkg::PH_FRAC_FIRST, rts_pkg::PH_FRAC: begin
                    if (r_phase == rts_pkg::PH_SEP && i_char == ".") begin
                        n_phase = rts_pkg::PH_FRAC_FIRST;
                    end else if (r_phase != rts_pkg::PH_SEP && rts_pkg::is_digit(i_char)) begin
                        if (r_fd != 2'd3) begin
                            n_ms = 10'(r_ms * 10'd10 + 10'(dig));
                            n_fd = r_fd + 2'd1;
                        end
                        n_phase = rts_pkg::PH_FRAC;
                    end else if (r_phase == rts_pkg::PH_FRAC_FIRST) begin
                        n_bad = 1'b1;
                    end else if (i_char == "Z" || i_char == "z") begin
                        n_phase = rts_pkg::PH_DONE;
                    end else if (i_char == "+" || i_char == "-") begin
                        n_neg = (i_char == "-");
                        n_pos = 5'd0;
                        n_phase = rts_pkg::PH_OFFSET;
                    end else begin
                        n_bad = 1'b1;
                    end
                end
                rts_pkg::PH_OFFSET: begin
                    if (r_pos == 5'd2) begin
                        if (i_char != ":") n_bad = 1'b1;
                    end else if (!rts_pkg::is_digit(i_char)) begin
                        n_bad = 1'b1;
                    end else if (r_pos < 5'd2) begin
                        n_zh = acc7(r_zh, dig);
                    end else begin
                        n_zm = acc7(r_zm, dig);
                    end
                    n_pos = r_pos + 5'd1;
                    if (r_pos == 5'd4) n_phase = rts_pkg::PH_DONE;
                end
                rts_pkg::PH_DONE: begin
                    if (!rts_pkg::is_ws(i_char)) n_bad = 1'b1;
                end
                default: n_bad = 1'b1;
            endcase
        end
    end

    // validity of the completed text
    always_comb begin
        // century year 100*c is leap when 4 divides c, i.e. when the year's low 4 bits are zero
        leap = (n_ylo == 7'd0) ? (n_year[3:0] == 4'd0) : (n_year[1:0] == 2'd0);
        case (n_mon)
            7'd2:                         mdays = leap ? 5'd29 : 5'd28;
            7'd4, 7'd6, 7'd9, 7'd11:      mdays = 5'd30;
            default:                      mdays = 5'd31;
        endcase
        good = !n_bad && n_phase == rts_pkg::PH_DONE && n_hr <= 7'd23 && n_mi <= 7'd59 &&
               n_se <= 7'd59 && n_mon >= 7'd1 && n_mon <= 7'd12 && n_day >= 7'd1 &&
               n_day <= 7'(mdays) && n_zh <= 7'd23 && n_zm <= 7'd59;
        case (n_fd)
            2'd0:    frac = 10'd0;
            2'd1:    frac = 10'(n_ms * 10'd100);
            2'd2:    frac = 10'(n_ms * 10'd10);
            default: frac = n_ms;
        endcase
    end

    // state registers; cleared after each final character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_phase <= rts_pkg::PH_LEAD; r_pos <= '0; r_year <= '0; r_ylo <= '0;
            r_mon <= '0; r_day <= '0; r_hr <= '0; r_mi <= '0; r_se <= '0; r_ms <= '0;
            r_fd <= '0; r_neg <= 1'b0; r_bad <= 1'b0; r_zh <= '0; r_zm <= '0;
        end else if (i_take) begin
            r_phase <= n_phase; r_pos <= n_pos; r_year <= n_year; r_ylo <= n_ylo;
            r_mon <= n_mon; r_day <= n_day; r_hr <= n_hr; r_mi <= n_mi; r_se <= n_se;
            r_ms <= n_ms; r_fd <= n_fd; r_neg <= n_neg; r_bad <= n_bad; r_zh <= n_zh;
            r_zm <= n_zm;
        end
    end

    // field snapshot handed to the datapath
    always_comb begin
        o_fields.good        = good;
        o_fields.year        = n_year;
        o_fields.month       = n_mon[3:0];
        o_fields.day         = n_day[4:0];
        o_fields.hour        = n_hr[4:0];
        o_fields.minute      = n_mi[5:0];
        o_fields.second      = n_se[5:0];
        o_fields.millis      = frac;
        o_fields.zone_neg    = n_neg;
        o_fields.zone_hour   = n_zh[4:0];
        o_fields.zone_minute = n_zm[5:0];
    end
endmodule

// ===== hdl/rts_datapath.sv =====
// Date to epoch conversion in steps: days, seconds, milliseconds.
module rts_datapath (
    input  logic                          i_clk,
    input  rts_pkg::t_cmd                 i_cmd,
    input  rts_pkg::t_fields              i_fields,
    output logic                          o_ok,
    output logic signed [rts_pkg::MsWidth-1:0] o_epoch_ms
);
    rts_pkg::t_fields   r_f;
    logic signed [23:0] r_days;
    logic signed [38:0] r_secs;
    logic signed [rts_pkg::MsWidth-1:0] r_ms;
    logic [14:0] yy;
    logic [3:0]  mp;
    logic [8:0]  doy;
    logic [27:0] q100;
    logic [8:0]  cent;
    logic [23:0] ydays;
    logic signed [23:0] days;
    logic signed [38:0] secs, off;

    // day of year at the first of each month, year starting in March
    function automatic logic [8:0] month_start(input logic [3:0] m);
        case (m)
            4'd0:    return 9'd0;
            4'd1:    return 9'd31;
            4'd2:    return 9'd61;
            4'd3:    return 9'd92;
            4'd4:    return 9'd122;
            4'd5:    return 9'd153;
            4'd6:    return 9'd184;
            4'd7:    return 9'd214;
            4'd8:    return 9'd245;
            4'd9:    return 9'd275;
            4'd10:   return 9'd306;
            4'd11:   return 9'd337;
            default: return 9'd0;
        endcase
    endfunction

    // days from year 0 shifted, closed form on year count
    always_comb begin
        yy   = 15'(r_f.year) - ((r_f.month <= 4'd2) ? 15'd1 : 15'd0) + 15'd400;
        mp   = (r_f.month > 4'd2) ? r_f.month - 4'd3 : r_f.month + 4'd9;
        doy  = month_start(mp) + 9'(r_f.day) - 9'd1;
        // yy / 100 by reciprocal, exact for yy below 10400
        q100 = 28'(yy) * 28'd5243;
        cent = q100[27:19];
        ydays = 24'(yy) * 24'd365 + 24'(yy >> 2) - 24'(cent) + 24'(cent >> 2);
        days = $signed(ydays + 24'(doy)) - 24'sd719468 - 24'sd146097;
        secs = 39'(r_days) * 39'sd86400 + 39'(r_f.hour) * 39'sd3600 +
               39'(r_f.minute) * 39'sd60 + 39'(r_f.second);
        off  = (39'(r_f.zone_hour) * 39'sd60 + 39'(r_f.zone_minute)) * 39'sd60;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load)    r_f <= i_fields;
        if (i_cmd.do_days) r_days <= days;
        if (i_cmd.do_secs) r_secs <= r_f.zone_neg ? secs + off : secs - off;
        if (i_cmd.do_ms)   r_ms <= r_f.good ?
            (49'(r_secs) * 49'sd1000 + 49'(r_f.millis)) : '0;
    end

    assign o_ok       = r_f.good;
    assign o_epoch_ms = r_ms;
endmodule

// ===== hdl/rts_ctrl.sv =====
// Sequencer for the conversion steps and the result handshake.
module rts_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_final,
    input  logic          i_out_ready,
    output rts_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_out_valid
);
    rts_pkg::t_cv_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rts_pkg::CV_IDLE: if (i_final) n_state = rts_pkg::CV_DAYS;
            rts_pkg::CV_DAYS: n_state = rts_pkg::CV_SECS;
            rts_pkg::CV_SECS: n_state = rts_pkg::CV_MS;
            rts_pkg::CV_MS:   n_state = rts_pkg::CV_OUT;
            rts_pkg::CV_OUT:  if (i_out_ready) n_state = rts_pkg::CV_IDLE;
            default:          n_state = rts_pkg::CV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= rts_pkg::CV_IDLE;
        else          r_state <= n_state;
    end

    assign o_cmd.load    = (r_state == rts_pkg::CV_IDLE) && i_final;
    assign o_cmd.do_days = (r_state == rts_pkg::CV_DAYS);
    assign o_cmd.do_secs = (r_state == rts_pkg::CV_SECS);
    assign o_cmd.do_ms   = (r_state == rts_pkg::CV_MS);
    assign o_busy        = (r_state != rts_pkg::CV_IDLE);
    assign o_out_valid   = (r_state == rts_pkg::CV_OUT);
endmodule

// ===== hdl/rfc3339_timestamp_to_unix_ms_unit.sv =====
// channel | dir | payload
// i_char  | in  | char_byte[7:0], last_char
// o_res   | out | ok, epoch_ms[48:0] signed
// One character per cycle while no conversion runs. After the last character
// the conversion runs its days, seconds and milliseconds multiplier steps, then
// the result waits for ready; characters are held off during that time.
// Reset is synchronous, active low; it returns the scanner to leading blanks.
module rfc3339_timestamp_to_unix_ms_unit (
    input  logic i_clk,
    input  logic i_rst_n,
    rts_char_if.sink     i_char,
    rts_result_if.source o_res
);
    rts_pkg::t_fields f;
    rts_pkg::t_cmd    cmd;
    logic busy, take;

    assign i_char.ready = !busy;
    assign take = i_char.valid && !busy;

    rts_parser u_parser (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(take),
        .i_char(i_char.char_byte), .i_last(i_char.last_char), .o_fields(f)
    );
    rts_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_final(take && i_char.last_char),
        .i_out_ready(o_res.ready), .o_cmd(cmd), .o_busy(busy), .o_out_valid(o_res.valid)
    );
    rts_datapath u_dp (
        .i_clk(i_clk), .i_cmd(cmd), .i_fields(f),
        .o_ok(o_res.ok), .o_epoch_ms(o_res.epoch_ms)
    );
endmodule

// ===== hdl/rts_checker.sv =====
module rts_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic in_last,
    input logic out_valid,
    input logic out_ready,
    input logic out_ok,
    input logic [rts_pkg::MsWidth-1:0] out_ms
);
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ok |-> out_ms == '0) else $error("nonzero ms on bad");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_ms)) else $error("result dropped");
    a_noin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");
    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready && in_last |=> ##3 out_valid) else $error("late result");
endmodule

bind rfc3339_timestamp_to_unix_ms_unit rts_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .in_valid(i_char.valid), .in_ready(i_char.ready),
    .in_last(i_char.last_char), .out_valid(o_res.valid), .out_ready(o_res.ready),
    .out_ok(o_res.ok), .out_ms(o_res.epoch_ms)
);
